// ===== hw/rtl/aes128_pkg.sv =====
// AES-128 package: S-box tables, GF helpers and round functions
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned AddrW = 4;

  localparam logic [AddrW-1:0] RegKeyHigh = 4'h0;
  localparam logic [AddrW-1:0] RegKeyLow  = 4'h8;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // round constants, index 0 for round 1
  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block sits at bits 127-8i -: 8
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift_fwd(input block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t sub_shift_inv(input block_t s);
    block_t o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(r+4*c) -: 8] = INV_SBOX[get_byte(s, r + 4*((c + 3*r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      o[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[127-8*(4*c+1) -: 8] = xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0;
      o[127-8*(4*c+2) -: 8] = xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1;
      o[127-8*(4*c+3) -: 8] = xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2;
    end
    return o;
  endfunction

  // inverse mix as fwd mix after a preconditioning step
  function automatic block_t mix_inv(input block_t s);
    block_t p;
    logic [7:0] a0, a1, a2, a3, u, v;
    p = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      p[127-8*(4*c)   -: 8] = a0 ^ u;
      p[127-8*(4*c+1) -: 8] = a1 ^ v;
      p[127-8*(4*c+2) -: 8] = a2 ^ u;
      p[127-8*(4*c+3) -: 8] = a3 ^ v;
    end
    return mix_fwd(p);
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== hw/rtl/aes128_block_cipher.sv =====
// AES-128 encrypt/decrypt top level with unrolled round pipeline
//
// Usage:
//   Input channel (valid/ready): operation (0 encrypt, 1 decrypt), data_high/data_low
//   hold block bytes 0..15, byte 0 in data_high[63:56]. Output channel gives
//   result_high/result_low in the same byte order, one transaction per input.
//   The key is written over the APB port: key_high at 0x0, key_low at 0x8.
//   The key schedule register chain is refreshed on every clock from the key;
//   after a key write, ready stays low while it settles. The key may only be
//   written while the pipeline is empty.
// Pipeline: initial key add, ten round stages, output register; decrypt reads the
//   round key registers in reverse order.
// Throughput: one block per cycle while the output is not stalled and no key write
//   is settling; each round is one pipeline stage with its own S-box lookups.
// Reset: clears the key and all valid bits; ready stays low after reset while
//   the round keys are re-derived.
// Stall: when the receiver holds ready low with the last stage full, the whole
//   pipeline holds and ready to the sender drops as well. No transaction
//   is lost or repeated.
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic        operation,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [aes128_pkg::AddrW-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned NR = aes128_pkg::NumRounds;
  localparam int unsigned SettleW = $clog2(NR + 2);
  localparam logic [SettleW-1:0] SettleCycles = SettleW'(NR + 1);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [SettleW-1:0] settle;

  // round keys rk[0..NR], combinational chain split by registers
  aes128_pkg::block_t rk [NR+1];

  logic                v   [NR+2];
  logic                op  [NR+1];
  aes128_pkg::block_t  st  [NR+2];
  logic                adv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == aes128_pkg::RegKeyHigh) begin
        key_high <= pwdata;
      end else if (paddr == aes128_pkg::RegKeyLow) begin
        key_low <= pwdata;
      end
    end
  end

  // hold off input until the round key chain reflects the key
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SettleCycles;
    end else if (psel && penable && pwrite) begin
      settle <= SettleCycles;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  always_comb begin
    case (paddr)
      aes128_pkg::RegKeyHigh: prdata = key_high;
      aes128_pkg::RegKeyLow:  prdata = key_low;
      default:                prdata = '0;
    endcase
  end

  // round key registers, each derived from the previous one
  always_ff @(posedge clk) begin
    rk[0] <= {key_high, key_low};
    for (int i = 1; i <= NR; i++) begin
      rk[i] <= aes128_pkg::next_round_key(rk[i-1], aes128_pkg::RCON[i-1]);
    end
  end

  // global stall: advance unless output is full and not taken
  assign adv   = !v[NR+1] || result_ready;
  assign ready = adv && (settle == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NR+1; i++) begin
        v[i] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= valid && ready;
      for (int i = 1; i <= NR+1; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op[0] <= operation;
      st[0] <= {data_high, data_low} ^
               ((operation == aes128_pkg::OpDecrypt) ? rk[NR] : rk[0]);
      for (int i = 1; i <= NR; i++) begin
        op[i] <= op[i-1];
        if (op[i-1] == aes128_pkg::OpEncrypt) begin
          if (i == NR) begin
            st[i] <= aes128_pkg::sub_shift_fwd(st[i-1]) ^ rk[i];
          end else begin
            st[i] <= aes128_pkg::mix_fwd(aes128_pkg::sub_shift_fwd(st[i-1])) ^ rk[i];
          end
        end else begin
          if (i == 1) begin
            st[i] <= aes128_pkg::sub_shift_inv(st[i-1]);
          end else begin
            st[i] <= aes128_pkg::sub_shift_inv(
                       aes128_pkg::mix_inv(st[i-1] ^ rk[NR+1-i]));
          end
        end
      end
      st[NR+1] <= (op[NR] == aes128_pkg::OpDecrypt) ? (st[NR] ^ rk[0]) : st[NR];
    end
  end

  assign result_valid = v[NR+1];
  assign result_high  = st[NR+1][127:64];
  assign result_low   = st[NR+1][63:0];

endmodule

// ===== test/testbench.sv =====
// Testbench for aes128_block_cipher: directed vectors and random blocks checked by a predictor
`timescale 1ns / 100ps

module testbench;

  localparam logic OP_ENC = aes128_pkg::OpEncrypt;
  localparam logic OP_DEC = aes128_pkg::OpDecrypt;
  localparam int LATENCY = 11;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic         op;
    logic [127:0] data;
    logic         has_expect;
    logic [127:0] expect_val;
  } vector_t;

  logic clk, rst;
  logic valid, ready, operation;
  logic [63:0] data_high, data_low;
  logic result_valid, result_ready;
  logic [63:0] result_high, result_low;
  logic psel, penable, pwrite;
  logic [aes128_pkg::AddrW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  logic [127:0] cipher_key;
  logic [127:0] expected_blocks[$];
  int errors;
  longint cycles;

  aes128_block_cipher uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] sbox_byte(input logic [7:0] x);
    logic [7:0] p, b, r;
    p = 8'd1;
    b = x;
    for (int e = 0; e < 8; e++) begin
      if (((254 >> e) & 1) != 0) p = gmul(p, b);
      b = gmul(b, b);
    end
    r = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]};
    return r ^ 8'h63;
  endfunction

  logic [7:0] fwd_tab[256];
  logic [7:0] inv_tab[256];

  function automatic logic [127:0] aes_compute(input logic op, input logic [127:0] blk,
                                               input logic [127:0] k);
    logic [7:0] rk[176];
    logic [7:0] s[16], t[16], col[4], tw[4], f, rc, acc;
    logic [7:0] mf[4], mi[4];
    logic [127:0] o;
    mf = '{8'd2, 8'd3, 8'd1, 8'd1};
    mi = '{8'd14, 8'd11, 8'd13, 8'd9};
    rc = 8'd1;
    for (int i = 0; i < 16; i++) begin
      rk[i] = k[127-8*i -: 8];
      s[i] = blk[127-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = tw[0];
        tw[0] = fwd_tab[tw[1]] ^ rc;
        tw[1] = fwd_tab[tw[2]];
        tw[2] = fwd_tab[tw[3]];
        tw[3] = fwd_tab[f];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ tw[j];
    end
    if (op == OP_ENC) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) t[i] = fwd_tab[s[i]];
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) s[rw+4*c] = t[rw+4*((c+rw)%4)];
        if (r != 10)
          for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) col[i] = s[4*c+i];
            for (int i = 0; i < 4; i++) begin
              acc = '0;
              for (int j = 0; j < 4; j++) acc ^= gmul(mf[j], col[(i+j)%4]);
              s[4*c+i] = acc;
            end
          end
        for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
      end
    end else begin
      for (int r = 10; r >= 1; r--) begin
        for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
        if (r != 10)
          for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) col[i] = s[4*c+i];
            for (int i = 0; i < 4; i++) begin
              acc = '0;
              for (int j = 0; j < 4; j++) acc ^= gmul(mi[j], col[(i+j)%4]);
              s[4*c+i] = acc;
            end
          end
        for (int i = 0; i < 16; i++) t[i] = s[i];
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) s[rw+4*c] = inv_tab[t[rw+4*((c+3*rw)%4)]];
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic write_key(input logic [aes128_pkg::AddrW-1:0] addr,
                           input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == aes128_pkg::RegKeyHigh) cipher_key[127:64] = value;
    else cipher_key[63:0] = value;
  endtask

  task automatic send_block(input logic op, input logic [127:0] blk, input bit has_exp,
                            input logic [127:0] exp_val);
    logic [127:0] predicted;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    predicted = aes_compute(op, blk, cipher_key);
    if (has_exp && predicted !== exp_val) begin
      report_mismatch("predictor high", predicted[127:64], exp_val[127:64]);
      report_mismatch("predictor low", predicted[63:0], exp_val[63:0]);
    end
    valid = 1'b1; operation = op; data_high = blk[127:64]; data_low = blk[63:0];
    @(posedge clk);
    while (!ready) @(posedge clk);
    expected_blocks.push_back(has_exp ? exp_val : predicted);
    @(negedge clk);
    valid = 1'b0;
  endtask

  task automatic drain;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // output side
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      result_ready = 1'b0;
      repeat (stall) @(negedge clk);
      result_ready = 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (expected_blocks.size() == 0) begin
        $display("unexpected result %h %h", result_high, result_low);
        errors++;
      end else begin
        logic [127:0] want;
        want = expected_blocks.pop_front();
        if (result_high !== want[127:64]) report_mismatch("result_high", result_high, want[127:64]);
        if (result_low !== want[63:0]) report_mismatch("result_low", result_low, want[63:0]);
      end
      @(negedge clk);
    end
  end

  vector_t directed[] = '{
    '{OP_ENC, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{OP_DEC, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, 128'h0},
    '{OP_ENC, {128{1'b1}}, 1'b0, 128'h0},
    '{OP_DEC, {128{1'b1}}, 1'b0, 128'h0},
    '{OP_DEC, 128'h0, 1'b0, 128'h0},
    '{OP_ENC, 128'h00112233445566778899aabbccddeeff, 1'b0, 128'h0}
  };
  vector_t fips[] = '{
    '{OP_ENC, 128'h00112233445566778899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{OP_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{OP_ENC, 128'h0, 1'b0, 128'h0},
    '{OP_ENC, {128{1'b1}}, 1'b0, 128'h0},
    '{OP_DEC, {128{1'b1}}, 1'b0, 128'h0},
    '{OP_ENC, 128'h8000000000000000_0000000000000001, 1'b0, 128'h0}
  };

  initial begin
    logic [127:0] blk;
    errors = 0; cycles = 0;
    cipher_key = '0;
    valid = 1'b0; operation = 1'b0; data_high = '0; data_low = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < 256; i++) begin
      fwd_tab[i] = sbox_byte(i[7:0]);
      inv_tab[fwd_tab[i]] = i[7:0];
    end
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_block(directed[i].op, directed[i].data, directed[i].has_expect,
                 directed[i].expect_val);
    drain();
    write_key(aes128_pkg::RegKeyHigh, 64'h0001020304050607);
    write_key(aes128_pkg::RegKeyLow, 64'h08090a0b0c0d0e0f);
    foreach (fips[i])
      send_block(fips[i].op, fips[i].data, fips[i].has_expect, fips[i].expect_val);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: begin
          write_key(aes128_pkg::RegKeyHigh, '1); write_key(aes128_pkg::RegKeyLow, '1);
        end
        1: begin
          write_key(aes128_pkg::RegKeyHigh, '0); write_key(aes128_pkg::RegKeyLow, '0);
        end
        2: begin
          write_key(aes128_pkg::RegKeyHigh, 64'h8000000000000000);
          write_key(aes128_pkg::RegKeyLow, 64'h1);
        end
        default: begin
          write_key(aes128_pkg::RegKeyHigh, {$urandom, $urandom});
          write_key(aes128_pkg::RegKeyLow, {$urandom, $urandom});
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0: blk = '0;
          1: blk = '1;
          2: blk = 128'h1 << $urandom_range(0, 127);
          default: blk = {$urandom, $urandom, $urandom, $urandom};
        endcase
        send_block(1'($urandom_range(0, 1)), blk, 1'b0, 128'h0);
      end
    end
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_block_cipher.sv
test/testbench.sv
